@@ design/signed_int_to_decimal_ascii_macros.svh @@
// Assertion helpers for the decimal text converter.
// Both sample on clk and hold off while rst_n is low.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication.
`define SDA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SDA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/s2dec_pkg.sv @@
package s2dec_pkg;

  // default sizes
  localparam int VALUE_WIDTH_DEF = 64;
  localparam int DIGIT_SLOTS_DEF = 20;

  // port field widths
  localparam int VALUE_IN_W  = 64;
  localparam int END_CHAR_W  = 8;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 8;

  typedef logic [7:0] byte_t;
  typedef logic [3:0] digit_t;

  localparam byte_t  CHAR_ZERO  = 8'h30;
  localparam byte_t  CHAR_MINUS = 8'h2D;

  // shift-and-add-3 correction
  localparam digit_t DABBLE_MIN = 4'd5;
  localparam digit_t DABBLE_ADD = 4'd3;

endpackage

@@ design/signed_int_to_decimal_ascii.sv @@
// Flow: bit-serial binary-to-BCD conversion (double dabble), then a leading-zero
//   skip that drops one zero digit per step, then one byte per cycle out while
//   out_tready allows it.
// Input: a new value is accepted only in IDLE, once the last byte of the
//   previous value has been loaded into the output register.
// Reset: rst_n synchronous, active low; clears the sequencer and output valid.
`include "signed_int_to_decimal_ascii_macros.svh"

module signed_int_to_decimal_ascii #(
  parameter int VALUE_WIDTH = s2dec_pkg::VALUE_WIDTH_DEF,
  parameter int DIGIT_SLOTS = s2dec_pkg::DIGIT_SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: value [63:0], end_char [71:64]
  input  logic [s2dec_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // out_tdata: out_byte [7:0]
  output logic [s2dec_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                               out_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready
);
  import s2dec_pkg::*;

  localparam int CW = $clog2(VALUE_WIDTH + 1);   // bit counter
  localparam int DW = $clog2(DIGIT_SLOTS + 1);   // digit counter
  localparam int BW = 4 * DIGIT_SLOTS;           // BCD shift register

  // Sequencer: IDLE takes a beat, CONV runs double dabble one bit per cycle,
  // SKIP drops leading zero digits, SIGN/DIGITS/TERM push bytes out.
  typedef enum logic [2:0] {
    S_IDLE, S_CONV, S_SKIP, S_SIGN, S_DIGITS, S_TERM
  } state_t;

  state_t                 state_r,    state_nxt;
  logic [VALUE_WIDTH-1:0] mag_r,      mag_nxt;
  logic [BW-1:0]          bcd_r,      bcd_nxt;
  logic [CW-1:0]          bit_cnt_r,  bit_cnt_nxt;
  logic [DW-1:0]          dig_cnt_r,  dig_cnt_nxt;
  logic                   neg_r,      neg_nxt;
  logic                   ovf_r,      ovf_nxt;    // magnitude needs more slots
  byte_t                  end_r,      end_nxt;
  logic                   oval_r,     oval_nxt;
  byte_t                  obyte_r,    obyte_nxt;
  logic                   olast_r,    olast_nxt;

  logic [VALUE_WIDTH-1:0] raw;
  logic [BW-1:0]          adj;
  digit_t                 top_dig;
  logic                   out_free;
  logic                   in_fire;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = oval_r;
  assign out_tdata  = obyte_r;
  assign out_tlast  = olast_r;
  assign out_free   = !oval_r || out_tready;
  assign raw        = in_tdata[VALUE_WIDTH-1:0];
  assign top_dig    = bcd_r[BW-1 -: 4];

  // add-3 correction on every BCD digit before the shift
  always_comb begin
    for (int i = 0; i < DIGIT_SLOTS; i++) begin
      adj[4*i +: 4] = (bcd_r[4*i +: 4] >= DABBLE_MIN) ?
                      bcd_r[4*i +: 4] + DABBLE_ADD : bcd_r[4*i +: 4];
    end
  end

  always_comb begin
    state_nxt   = state_r;
    mag_nxt     = mag_r;
    bcd_nxt     = bcd_r;
    bit_cnt_nxt = bit_cnt_r;
    dig_cnt_nxt = dig_cnt_r;
    neg_nxt     = neg_r;
    ovf_nxt     = ovf_r;
    end_nxt     = end_r;
    oval_nxt    = oval_r && !out_tready;
    obyte_nxt   = obyte_r;
    olast_nxt   = olast_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          neg_nxt     = raw[VALUE_WIDTH-1];
          mag_nxt     = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
          end_nxt     = in_tdata[VALUE_IN_W +: END_CHAR_W];
          bcd_nxt     = '0;
          ovf_nxt     = 1'b0;
          bit_cnt_nxt = CW'(VALUE_WIDTH);
          dig_cnt_nxt = DW'(DIGIT_SLOTS);
          state_nxt   = S_CONV;
        end
      end
      S_CONV: begin
        // magnitude MSB enters; a bit leaving the top digit means overflow
        bcd_nxt     = {adj[BW-2:0], mag_r[VALUE_WIDTH-1]};
        ovf_nxt     = ovf_r || adj[BW-1];
        mag_nxt     = {mag_r[VALUE_WIDTH-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r - 1'b1;
        if (bit_cnt_r == CW'(1)) begin
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        // truncated values print every kept slot, zeros included
        if (!ovf_r && (dig_cnt_r != DW'(1)) && (top_dig == '0)) begin
          bcd_nxt     = {bcd_r[BW-5:0], 4'b0000};
          dig_cnt_nxt = dig_cnt_r - 1'b1;
        end else begin
          state_nxt = neg_r ? S_SIGN : S_DIGITS;
        end
      end
      S_SIGN: begin
        if (out_free) begin
          oval_nxt  = 1'b1;
          obyte_nxt = CHAR_MINUS;
          olast_nxt = 1'b0;
          state_nxt = S_DIGITS;
        end
      end
      S_DIGITS: begin
        if (out_free) begin
          oval_nxt    = 1'b1;
          obyte_nxt   = CHAR_ZERO + {4'b0000, top_dig};
          olast_nxt   = (dig_cnt_r == DW'(1)) && (end_r == '0);
          bcd_nxt     = {bcd_r[BW-5:0], 4'b0000};
          dig_cnt_nxt = dig_cnt_r - 1'b1;
          if (dig_cnt_r == DW'(1)) begin
            state_nxt = (end_r != '0) ? S_TERM : S_IDLE;
          end
        end
      end
      S_TERM: begin
        if (out_free) begin
          oval_nxt  = 1'b1;
          obyte_nxt = end_r;
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      oval_r  <= oval_nxt;
    end
    mag_r     <= mag_nxt;
    bcd_r     <= bcd_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    dig_cnt_r <= dig_cnt_nxt;
    neg_r     <= neg_nxt;
    ovf_r     <= ovf_nxt;
    end_r     <= end_nxt;
    obyte_r   <= obyte_nxt;
    olast_r   <= olast_nxt;
  end

  `SDA_ASSERT_NEXT(a_accept_starts_conv, in_fire, state_r == S_CONV, "no conversion after beat")
  `SDA_ASSERT_NOW(a_digits_left, state_r == S_DIGITS, dig_cnt_r != '0, "no digits left")
  `SDA_ASSERT_NOW(a_ovf_keeps_all, (state_r == S_SKIP) && ovf_r,
                  dig_cnt_r == DW'(DIGIT_SLOTS), "leading zeros skipped on a truncated value")
  `SDA_ASSERT_NOW(a_conv_count, state_r == S_CONV, bit_cnt_r != '0, "ran past value width")

endmodule
